[rtl/aabb_zpl_pkg.sv]
// ----------------------------------------------------------------------------
// Zone/portal linker package
// Shared item types, command codes and register constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabb_zpl_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_ZONE   = 2'd0;
	localparam logic [1:0] KIND_PORTAL = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_VALIDITY = 1'b0;
	localparam logic REG_LINK     = 1'b1;

	// Register reset values, raw Q16.16.
	localparam logic [30:0] VALIDITY_RESET = 31'd131072;
	localparam logic [30:0] LINK_RESET     = 31'd6554;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Fewest linked zones that make a portal usable.
	localparam int MIN_LINKS = 2;

	// Commands that the front hands to the back.
	typedef enum logic [1:0] {
		OP_ZONE,
		OP_PORTAL,
		OP_CLEAR
	} op_t;

	localparam int OP_BITS = 2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               last_vertex;
	} in_item_t;

	typedef struct packed {
		logic [15:0] portal_number;
		logic [31:0] link_mask;
		logic [5:0]  link_count;
		logic        used_fallback;
	} out_item_t;

endpackage

`default_nettype wire

[rtl/aabb_zone_portal_linker_top.sv]
// ----------------------------------------------------------------------------
// Zone/portal linker top level
// Vertex boxes for zones and portals; each kept portal yields a zone link mask.
// ----------------------------------------------------------------------------
// Vertex transfers are taken one per cycle while the command queue has room.
// A zone or clear is handled while the back end stays idle; a portal moves it to
// the zone store walk, which reads one stored zone per cycle, and then to a finish
// state that loads the result into the output register once the walk pipeline has
// drained and the output register is free.
// Reset clears control state and restores both tolerances; store contents stay
// undefined, since only entries below the zone count are read.
`timescale 1ns / 1ps
`default_nettype none

module aabb_zone_portal_linker_top import aabb_zpl_pkg::*; #(
	parameter int MAX_ZONES  = 32,
	parameter int COORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [30:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data
);

	localparam int CMD_BITS = OP_BITS + 6 * COORD_BITS;

	logic                       f_valid;
	logic                       f_ready;
	op_t                        f_op;
	logic [2:0][COORD_BITS-1:0] f_lo;
	logic [2:0][COORD_BITS-1:0] f_hi;
	logic [CMD_BITS-1:0]        q_wr_data;
	logic [CMD_BITS-1:0]        q_rd_data;
	logic                       b_valid;
	logic                       b_ready;
	op_t                        b_op;
	logic [2:0][COORD_BITS-1:0] b_lo;
	logic [2:0][COORD_BITS-1:0] b_hi;

	// Front end: box accumulation and classification.
	aabb_zpl_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd_op   (f_op),
		.cmd_lo   (f_lo),
		.cmd_hi   (f_hi)
	);

	assign q_wr_data = {f_op, f_hi, f_lo};

	// Command queue.
	aabb_zpl_queue #(
		.WIDTH(CMD_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (q_wr_data),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data (q_rd_data)
	);

	assign b_op = op_t'(q_rd_data[CMD_BITS-1 -: OP_BITS]);
	assign b_hi = q_rd_data[6*COORD_BITS-1:3*COORD_BITS];
	assign b_lo = q_rd_data[3*COORD_BITS-1:0];

	// Back end: zone store and portal walk.
	aabb_zpl_back #(
		.MAX_ZONES (MAX_ZONES),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd_op   (b_op),
		.cmd_lo   (b_lo),
		.cmd_hi   (b_hi),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

[rtl/aabb_zpl_front.sv]
// ----------------------------------------------------------------------------
// Zone/portal linker front end
// Takes vertex transfers, grows the running box and issues one command per
// finished object or clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_zpl_front import aabb_zpl_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire in_item_t                     in_data,
	output logic                              cmd_valid,
	input  wire logic                         cmd_ready,
	output op_t                               cmd_op,
	output logic [2:0][COORD_BITS-1:0]        cmd_lo,
	output logic [2:0][COORD_BITS-1:0]        cmd_hi
);

	logic                       open_q;
	logic [2:0][COORD_BITS-1:0] run_lo_q;
	logic [2:0][COORD_BITS-1:0] run_hi_q;
	logic [2:0][31:0]           pos_in;
	logic [2:0][COORD_BITS-1:0] pos_w;
	logic [2:0][COORD_BITS-1:0] new_lo;
	logic [2:0][COORD_BITS-1:0] new_hi;
	logic                       accept;
	logic                       is_vertex;
	logic                       is_clear;

	// A transfer is taken whenever the queue has room for a command.
	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;
	assign is_vertex = (in_data.kind == KIND_ZONE) || (in_data.kind == KIND_PORTAL);
	assign is_clear  = (in_data.kind == KIND_CLEAR);

	// Wrap each coordinate to the stored width and grow the box.
	always_comb begin
		logic signed [63:0] ext;
		pos_in = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
		for (int a = 0; a < 3; a++) begin
			ext      = 64'($signed(pos_in[a]));
			pos_w[a] = ext[COORD_BITS-1:0];
			if (!open_q) begin
				new_lo[a] = pos_w[a];
				new_hi[a] = pos_w[a];
			end else begin
				new_lo[a] = ($signed(pos_w[a]) < $signed(run_lo_q[a])) ? pos_w[a] : run_lo_q[a];
				new_hi[a] = ($signed(pos_w[a]) > $signed(run_hi_q[a])) ? pos_w[a] : run_hi_q[a];
			end
		end
	end

	// A command goes out for a clear or for the last vertex of an object.
	assign cmd_valid = accept && (is_clear || (is_vertex && in_data.last_vertex));
	assign cmd_op    = is_clear ? OP_CLEAR :
	                   (in_data.kind == KIND_PORTAL) ? OP_PORTAL : OP_ZONE;
	assign cmd_lo    = new_lo;
	assign cmd_hi    = new_hi;

	// Object state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (accept) begin
			if (is_clear) begin
				open_q <= 1'b0;
			end else if (is_vertex) begin
				open_q <= !in_data.last_vertex;
			end
		end
	end

	// Running box.
	always_ff @(posedge clk) begin
		if (accept && is_vertex) begin
			run_lo_q <= new_lo;
			run_hi_q <= new_hi;
		end
	end

endmodule

`default_nettype wire

[rtl/aabb_zpl_queue.sv]
// ----------------------------------------------------------------------------
// Zone/portal linker command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_zpl_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] fill_q;
	logic                push;
	logic                pop;

	assign wr_ready = (fill_q != CNT_BITS'(DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

[rtl/aabb_zpl_back.sv]
// ----------------------------------------------------------------------------
// Zone/portal linker back end
// Stores zone boxes, walks the store for each portal and builds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_zpl_back import aabb_zpl_pkg::*; #(
	parameter int MAX_ZONES  = 32,
	parameter int COORD_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [30:0]           cfg_wdata,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire op_t                   cmd_op,
	input  wire logic [2:0][COORD_BITS-1:0] cmd_lo,
	input  wire logic [2:0][COORD_BITS-1:0] cmd_hi,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data
);

	localparam int ZIDX_BITS = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int CNT_BITS  = $clog2(MAX_ZONES + 1);
	localparam int EXT_BITS  = ((COORD_BITS > 31) ? COORD_BITS : 31) + 2;
	localparam int BOX_BITS  = 6 * COORD_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t                     state_q;
	logic [30:0]                validity_slack_q;
	logic [30:0]                link_slack_q;
	logic [CNT_BITS-1:0]        zone_count_q;
	logic [15:0]                kept_q;
	logic [BOX_BITS-1:0]        zone_mem [MAX_ZONES];
	logic [2:0][COORD_BITS-1:0] run_lo_q;
	logic [2:0][COORD_BITS-1:0] run_hi_q;
	logic [CNT_BITS-1:0]        rd_idx_q;
	logic                       rd_en;
	logic                       zone_wr;

	// Read pipeline: s1 holds memory data, s2 holds slack-adjusted bounds.
	logic                              v_s1;
	logic [ZIDX_BITS-1:0]              idx_s1;
	logic [BOX_BITS-1:0]               box_s1;
	logic                              v_s2;
	logic [ZIDX_BITS-1:0]              idx_s2;
	logic signed [2:0][EXT_BITS-1:0]   vlo_s2;
	logic signed [2:0][EXT_BITS-1:0]   vhi_s2;
	logic signed [2:0][EXT_BITS-1:0]   llo_s2;
	logic signed [2:0][EXT_BITS-1:0]   lhi_s2;

	logic [MAX_ZONES-1:0]       vmask_q;
	logic [MAX_ZONES-1:0]       lmask_q;
	logic [CNT_BITS-1:0]        vcnt_q;
	logic [CNT_BITS-1:0]        lcnt_q;
	logic                       hit_v;
	logic                       hit_l;

	logic                       out_free;
	logic                       sel_fb;
	logic [MAX_ZONES-1:0]       sel_mask;
	logic [CNT_BITS-1:0]        sel_cnt;
	logic [63:0]                mask_wide;
	logic [31:0]                cnt_wide;
	logic                       emit;
	out_item_t                  out_q;
	logic                       out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			validity_slack_q <= VALIDITY_RESET;
			link_slack_q     <= LINK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VALIDITY: validity_slack_q <= cfg_wdata;
				REG_LINK:     link_slack_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign rd_en     = (state_q == ST_WALK) && (rd_idx_q < zone_count_q);
	assign zone_wr   = cmd_valid && cmd_ready && (cmd_op == OP_ZONE) &&
	                   (zone_count_q < CNT_BITS'(MAX_ZONES));

	// Zone store: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (zone_wr) begin
			zone_mem[zone_count_q[ZIDX_BITS-1:0]] <= {cmd_hi, cmd_lo};
		end
		if (rd_en) begin
			box_s1 <= zone_mem[rd_idx_q[ZIDX_BITS-1:0]];
		end
	end

	// Slack-adjusted zone bounds for both tolerances.
	always_ff @(posedge clk) begin
		logic [2:0][COORD_BITS-1:0] zlo;
		logic [2:0][COORD_BITS-1:0] zhi;
		zlo = box_s1[3*COORD_BITS-1:0];
		zhi = box_s1[BOX_BITS-1:3*COORD_BITS];
		idx_s2 <= idx_s1;
		for (int a = 0; a < 3; a++) begin
			vlo_s2[a] <= EXT_BITS'($signed(zlo[a])) - $signed(EXT_BITS'(validity_slack_q));
			vhi_s2[a] <= EXT_BITS'($signed(zhi[a])) + $signed(EXT_BITS'(validity_slack_q));
			llo_s2[a] <= EXT_BITS'($signed(zlo[a])) - $signed(EXT_BITS'(link_slack_q));
			lhi_s2[a] <= EXT_BITS'($signed(zhi[a])) + $signed(EXT_BITS'(link_slack_q));
		end
	end

	// Overlap tests of the portal box against the adjusted bounds.
	// Elements of a packed array are unsigned, so each is compared as signed.
	always_comb begin
		logic signed [EXT_BITS-1:0] rlo;
		logic signed [EXT_BITS-1:0] rhi;
		hit_v = 1'b1;
		hit_l = 1'b1;
		for (int a = 0; a < 3; a++) begin
			rlo = EXT_BITS'($signed(run_lo_q[a]));
			rhi = EXT_BITS'($signed(run_hi_q[a]));
			if (rhi < $signed(vlo_s2[a]) || rlo > $signed(vhi_s2[a])) begin
				hit_v = 1'b0;
			end
			if (rhi < $signed(llo_s2[a]) || rlo > $signed(lhi_s2[a])) begin
				hit_l = 1'b0;
			end
		end
	end

	// Result selection.
	always_comb begin
		sel_fb    = (lcnt_q < CNT_BITS'(MIN_LINKS));
		sel_mask  = sel_fb ? vmask_q : lmask_q;
		sel_cnt   = sel_fb ? vcnt_q : lcnt_q;
		mask_wide = 64'(sel_mask);
		cnt_wide  = 32'(sel_cnt);
	end

	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == ST_FINISH) && out_free &&
	                  (vcnt_q >= CNT_BITS'(MIN_LINKS));

	// Sequencer, store bookkeeping, walk and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			zone_count_q <= '0;
			kept_q       <= '0;
			rd_idx_q     <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			idx_s1       <= '0;
			vmask_q      <= '0;
			lmask_q      <= '0;
			vcnt_q       <= '0;
			lcnt_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1   <= rd_en;
			v_s2   <= v_s1;
			idx_s1 <= rd_idx_q[ZIDX_BITS-1:0];

			// A new result takes the output register as the old one leaves.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Accumulate one tested zone a cycle.
			if (v_s2) begin
				if (hit_v) begin
					vmask_q[idx_s2] <= 1'b1;
					vcnt_q          <= vcnt_q + 1'b1;
				end
				if (hit_l) begin
					lmask_q[idx_s2] <= 1'b1;
					lcnt_q          <= lcnt_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd_op)
							OP_ZONE: begin
								if (zone_wr) begin
									zone_count_q <= zone_count_q + 1'b1;
								end
							end
							OP_PORTAL: begin
								rd_idx_q <= '0;
								vmask_q  <= '0;
								lmask_q  <= '0;
								vcnt_q   <= '0;
								lcnt_q   <= '0;
								state_q  <= ST_WALK;
							end
							OP_CLEAR: begin
								zone_count_q <= '0;
								kept_q       <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (emit) begin
							kept_q <= kept_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Portal box capture and result payload.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready && (cmd_op == OP_PORTAL)) begin
			run_lo_q <= cmd_lo;
			run_hi_q <= cmd_hi;
		end
		if (emit) begin
			out_q.portal_number <= kept_q;
			out_q.link_mask     <= mask_wide[31:0];
			out_q.link_count    <= (cnt_wide > 32'd63) ? 6'd63 : cnt_wide[5:0];
			out_q.used_fallback <= sel_fb;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The store never holds more zones than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		zone_count_q <= CNT_BITS'(MAX_ZONES))
		else $error("zone count beyond store size");

	// Only written entries are read during a walk.
	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_idx_q < zone_count_q))
		else $error("store read beyond written entries");

	// A result carries at least the minimum number of linked zones.
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (sel_cnt >= CNT_BITS'(MIN_LINKS)))
		else $error("result with too few links");

	// The walk pipeline is empty when a portal finishes.
	a_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!v_s1 && !v_s2 && !rd_en))
		else $error("portal finished with tests in flight");

	// A result is only loaded while the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result overwrote a waiting result");

endmodule

`default_nettype wire

[bench/aabb_zone_portal_linker_top_tb.sv]
// ----------------------------------------------------------------------------
// Zone/portal linker testbench
// Streams zone and portal vertices into the linker under random input gaps and
// output stalls. The bench keeps its own model of the box store, predicts every
// link result, and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_zone_portal_linker_top_tb;
	import aabb_zpl_pkg::*;

	localparam int MAX_ZONES = 32;
	localparam int COORD_BITS = 32;

	// The kind code that the block ignores.
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	localparam longint ONE = 64'sd65536;
	localparam longint HEIGHT = 4 * ONE;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam logic [30:0] SLACK_MAX = 31'h7FFF_FFFF;

	// Idle time after the last result, enough for two queued portal walks.
	localparam int SETTLE_CYCLES = 128;
	localparam int DRAIN_LIMIT = 50000;

	typedef longint vec3_t [3];

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [30:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	aabb_zone_portal_linker_top #(
		.MAX_ZONES(MAX_ZONES),
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Bench copy of the linker state.
	longint box_lo [3];
	longint box_hi [3];
	bit box_open;
	longint zone_lo_q [MAX_ZONES][3];
	longint zone_hi_q [MAX_ZONES][3];
	int unsigned zones_held;
	logic [15:0] portals_kept;
	logic [30:0] validity_q;
	logic [30:0] link_q;

	out_item_t expected_links [$];
	out_item_t link_want;
	int mismatch_count = 0;
	int items_sent = 0;

	// Idle controls for the sender and the receiver.
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold_req = 0;

	// Layout of the current scene of zones.
	longint scene_x0;
	longint scene_y0;
	longint scene_z0;
	longint scene_cell;
	int scene_zones;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// True when the open box lies within the slack of stored zone z on every axis.
	function automatic bit zone_reached(int unsigned z, longint slack);
		for (int a = 0; a < 3; a++) begin
			if (box_hi[a] < zone_lo_q[z][a] - slack || box_lo[a] > zone_hi_q[z][a] + slack)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advances the bench model by one accepted input item and queues any result.
	task automatic predict_link(input in_item_t it);
		longint p [3];
		logic [31:0] vmask;
		logic [31:0] lmask;
		int unsigned vcnt;
		int unsigned lcnt;
		int unsigned cnt;
		bit fallback;
		out_item_t res;
		if (it.kind == KIND_RESERVED)
			return;
		if (it.kind == KIND_CLEAR) begin
			zones_held = 0;
			portals_kept = '0;
			box_open = 1'b0;
			return;
		end
		p[0] = longint'($signed(it.pos_x));
		p[1] = longint'($signed(it.pos_y));
		p[2] = longint'($signed(it.pos_z));
		for (int a = 0; a < 3; a++) begin
			if (!box_open) begin
				box_lo[a] = p[a];
				box_hi[a] = p[a];
			end else begin
				if (p[a] < box_lo[a])
					box_lo[a] = p[a];
				if (p[a] > box_hi[a])
					box_hi[a] = p[a];
			end
		end
		box_open = 1'b1;
		if (!it.last_vertex)
			return;
		box_open = 1'b0;

		// A finished zone is stored while there is room.
		if (it.kind == KIND_ZONE) begin
			if (zones_held < MAX_ZONES) begin
				for (int a = 0; a < 3; a++) begin
					zone_lo_q[zones_held][a] = box_lo[a];
					zone_hi_q[zones_held][a] = box_hi[a];
				end
				zones_held++;
			end
			return;
		end

		// A finished portal is tested against every stored zone.
		vmask = '0;
		lmask = '0;
		vcnt = 0;
		lcnt = 0;
		for (int unsigned z = 0; z < zones_held; z++) begin
			if (zone_reached(z, longint'(validity_q))) begin
				if (z < 32)
					vmask[z] = 1'b1;
				vcnt++;
			end
			if (zone_reached(z, longint'(link_q))) begin
				if (z < 32)
					lmask[z] = 1'b1;
				lcnt++;
			end
		end
		if (vcnt < MIN_LINKS)
			return;
		fallback = (lcnt < MIN_LINKS);
		cnt = fallback ? vcnt : lcnt;
		if (cnt > 63)
			cnt = 63;
		res.portal_number = portals_kept;
		res.link_mask = fallback ? vmask : lmask;
		res.link_count = 6'(cnt);
		res.used_fallback = fallback;
		expected_links = {expected_links, res};
		portals_kept++;
	endtask

	// Compares each output transfer with the oldest predicted result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_links.size() == 0) begin
				$error("unexpected result: portal_number %0d link_mask %h",
					out_data.portal_number, out_data.link_mask);
				mismatch_count++;
			end else begin
				link_want = expected_links.pop_front();
				if (out_data.portal_number !== link_want.portal_number) begin
					$error("portal_number: expected %0d, got %0d",
						link_want.portal_number, out_data.portal_number);
					mismatch_count++;
				end
				if (out_data.link_mask !== link_want.link_mask) begin
					$error("link_mask: expected %h, got %h",
						link_want.link_mask, out_data.link_mask);
					mismatch_count++;
				end
				if (out_data.link_count !== link_want.link_count) begin
					$error("link_count: expected %0d, got %0d",
						link_want.link_count, out_data.link_count);
					mismatch_count++;
				end
				if (out_data.used_fallback !== link_want.used_fallback) begin
					$error("used_fallback: expected %0d, got %0d",
						link_want.used_fallback, out_data.used_fallback);
					mismatch_count++;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold when one is requested.
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one item, waits for its transfer, then maybe idles for a burst.
	task automatic send_item(input in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_link(it);
		if (it.kind != KIND_RESERVED)
			items_sent++;
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Waits until every predicted result has arrived and the back end is quiet.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_links.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slack(input logic idx, input logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_VALIDITY)
			validity_q = val;
		else
			link_q = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [1:0] kind, longint x, longint y, longint z,
		bit last);
		in_item_t it;
		it.kind = kind;
		it.pos_x = x[31:0];
		it.pos_y = y[31:0];
		it.pos_z = z[31:0];
		it.last_vertex = last;
		return it;
	endfunction

	function automatic longint pick_between(longint lo, longint hi);
		logic [63:0] r;
		longint span;
		span = hi - lo;
		if (span <= 0)
			return lo;
		r = {$urandom, $urandom};
		return lo + longint'(r % (span + 1));
	endfunction

	// Starts a fresh scene somewhere in the coordinate space.
	task automatic new_scene();
		scene_x0 = longint'($signed($urandom)) / 2;
		scene_y0 = longint'($signed($urandom)) / 2;
		scene_z0 = longint'($signed($urandom)) / 2;
		scene_cell = ONE * longint'($urandom_range(1, 4));
		scene_zones = 0;
	endtask

	task automatic send_clear();
		send_item(make_item(KIND_CLEAR, longint'($signed($urandom)),
			longint'($signed($urandom)), longint'($signed($urandom)), $urandom_range(0, 1)));
		new_scene();
	endtask

	// Sends an object whose vertices span exactly the box lo..hi; a single vertex sits at lo.
	task automatic send_box(input logic [1:0] kind, input vec3_t lo, input vec3_t hi,
		input int nverts, input bit mixed);
		in_item_t it;
		bit hi_first;
		vec3_t c;
		hi_first = $urandom_range(0, 1);
		for (int v = 0; v < nverts; v++) begin
			for (int a = 0; a < 3; a++) begin
				if (v == 0)
					c[a] = (hi_first && nverts > 1) ? hi[a] : lo[a];
				else if (v == nverts - 1)
					c[a] = hi_first ? lo[a] : hi[a];
				else
					c[a] = pick_between(lo[a], hi[a]);
			end
			// Only the last vertex decides what the object is.
			if (mixed && v != nverts - 1)
				it.kind = $urandom_range(0, 1) ? KIND_PORTAL : KIND_ZONE;
			else
				it.kind = kind;
			it.pos_x = c[0][31:0];
			it.pos_y = c[1][31:0];
			it.pos_z = c[2][31:0];
			it.last_vertex = (v == nverts - 1);
			send_item(it);
		end
	endtask

	// Places the next zone of the scene in a row of cells, touching or nearly so.
	task automatic place_zone();
		vec3_t lo;
		vec3_t hi;
		longint gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, ONE / 2));
		lo[0] = scene_x0 + longint'(scene_zones) * scene_cell;
		hi[0] = lo[0] + scene_cell - gap;
		lo[1] = scene_y0 + longint'($urandom_range(0, ONE / 4));
		hi[1] = scene_y0 + HEIGHT - longint'($urandom_range(0, ONE / 4));
		lo[2] = scene_z0 + longint'($urandom_range(0, ONE / 4));
		hi[2] = scene_z0 + HEIGHT - longint'($urandom_range(0, ONE / 4));
		send_box(KIND_ZONE, lo, hi, $urandom_range(1, 4), $urandom_range(0, 9) == 0);
		scene_zones++;
	endtask

	// Places a portal near a cell boundary, or a wide one across several cells.
	task automatic place_portal();
		vec3_t lo;
		vec3_t hi;
		longint cx;
		longint half;
		int span;
		span = (scene_zones < 32) ? scene_zones : 32;
		if ($urandom_range(0, 4) == 0) begin
			lo[0] = scene_x0 + longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
			hi[0] = lo[0] + scene_cell * longint'($urandom_range(0, 12));
		end else begin
			cx = scene_x0 + longint'($urandom_range(0, span)) * scene_cell
				+ longint'($urandom_range(0, 6 * ONE)) - 3 * ONE;
			half = longint'($urandom_range(0, ONE / 4));
			lo[0] = cx - half;
			hi[0] = cx + half;
		end
		for (int a = 1; a < 3; a++) begin
			lo[a] = ((a == 1) ? scene_y0 : scene_z0) + longint'($urandom_range(0, HEIGHT));
			// Now and then the portal misses the row on this axis.
			if ($urandom_range(0, 9) == 0)
				lo[a] = lo[a] + HEIGHT + longint'($urandom_range(0, 3 * ONE));
			hi[a] = lo[a] + longint'($urandom_range(0, ONE));
		end
		send_box(KIND_PORTAL, lo, hi, $urandom_range(1, 4), $urandom_range(0, 9) == 0);
	endtask

	// Random mix: mostly scenes of zones and portals, with noise and broken objects.
	task automatic run_scenes(input int n);
		int target;
		int r;
		int nb;
		in_item_t it;
		target = items_sent + n;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_clear();
			end else if (r < 8) begin
				it = make_item(2'($urandom_range(0, 3)), longint'($signed($urandom)),
					longint'($signed($urandom)), longint'($signed($urandom)),
					$urandom_range(0, 1));
				send_item(it);
				if (it.kind == KIND_CLEAR)
					new_scene();
			end else if (r < 12) begin
				// Object left open and then abandoned by a clear.
				nb = $urandom_range(1, 3);
				repeat (nb) begin
					send_item(make_item($urandom_range(0, 1) ? KIND_PORTAL : KIND_ZONE,
						scene_x0 + longint'($urandom_range(0, 8 * ONE)),
						scene_y0 + longint'($urandom_range(0, HEIGHT)),
						scene_z0 + longint'($urandom_range(0, HEIGHT)), 1'b0));
				end
				send_clear();
			end else if (r < 55 && scene_zones < 36) begin
				place_zone();
			end else begin
				place_portal();
			end
		end
	endtask

	// Extremes, fallback, dropped portals, reserved kind, mixed kinds, clear mid-object.
	task automatic test_directed_cases();
		send_item(make_item(KIND_CLEAR, 0, 0, 0, 1'b0));
		// Two zones with a half-unit gap between them.
		send_item(make_item(KIND_ZONE, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_ZONE, ONE, 4 * ONE, 4 * ONE, 1'b1));
		send_item(make_item(KIND_ZONE, ONE + ONE / 2, 0, 0, 1'b0));
		send_item(make_item(KIND_ZONE, 5 * ONE / 2, 4 * ONE, 4 * ONE, 1'b1));
		// Point portal in the gap: only the validity tolerance reaches both zones.
		send_item(make_item(KIND_PORTAL, ONE + ONE / 5, 2 * ONE, 2 * ONE, 1'b1));
		// Portal across the gap: the link tolerance reaches both zones.
		send_item(make_item(KIND_PORTAL, 62259, 2 * ONE, 2 * ONE, 1'b0));
		send_item(make_item(KIND_PORTAL, 101581, 2 * ONE, 2 * ONE, 1'b1));
		// Portal far from everything is dropped.
		send_item(make_item(KIND_PORTAL, 100 * ONE, 2 * ONE, 2 * ONE, 1'b1));
		// Zones at the coordinate extremes.
		send_item(make_item(KIND_ZONE, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		send_item(make_item(KIND_ZONE, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		// Portal covering the whole space links every stored zone.
		send_item(make_item(KIND_PORTAL, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
		send_item(make_item(KIND_PORTAL, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		// Reserved kind is ignored whatever it carries.
		send_item(make_item(KIND_RESERVED, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		send_item(make_item(KIND_RESERVED, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
		// Mixed kinds: the last vertex decides the object type.
		send_item(make_item(KIND_ZONE, 2 * ONE, 2 * ONE, 2 * ONE, 1'b0));
		send_item(make_item(KIND_PORTAL, ONE / 2, 2 * ONE, 2 * ONE, 1'b1));
		send_item(make_item(KIND_PORTAL, 3 * ONE, 0, 0, 1'b0));
		send_item(make_item(KIND_ZONE, 3 * ONE, ONE, ONE, 1'b1));
		// Clear in the middle of an object abandons it and empties the store.
		send_item(make_item(KIND_PORTAL, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		send_item(make_item(KIND_PORTAL, 0, 0, 0, 1'b1));
		send_item(make_item(KIND_ZONE, 0, 0, 0, 1'b1));
		send_item(make_item(KIND_ZONE, 0, 0, 0, 1'b1));
		send_item(make_item(KIND_PORTAL, 0, 0, 0, 1'b1));
		new_scene();
	endtask

	// Fills the store past its capacity, then links a portal across every zone.
	task automatic test_store_full();
		vec3_t lo;
		vec3_t hi;
		send_clear();
		repeat (MAX_ZONES + 2) place_zone();
		lo[0] = scene_x0 - ONE;
		hi[0] = scene_x0 + 40 * scene_cell;
		lo[1] = scene_y0 + ONE;
		hi[1] = scene_y0 + 2 * ONE;
		lo[2] = scene_z0 + ONE;
		hi[2] = scene_z0 + 2 * ONE;
		send_box(KIND_PORTAL, lo, hi, 2, 1'b0);
		repeat (6) place_portal();
	endtask

	// Runs random scenes under several tolerance settings, extremes included.
	task automatic test_slack_settings();
		logic [30:0] vs;
		logic [30:0] ls;
		for (int k = 0; k < 7; k++) begin
			case (k)
				0: begin
					vs = '0;
					ls = '0;
				end
				1: begin
					vs = SLACK_MAX;
					ls = SLACK_MAX;
				end
				2: begin
					vs = SLACK_MAX;
					ls = '0;
				end
				3: begin
					vs = '0;
					ls = SLACK_MAX;
				end
				4: begin
					vs = 31'($urandom_range(0, 4 * ONE));
					ls = 31'($urandom_range(0, ONE / 2));
				end
				5: begin
					vs = 31'($urandom);
					ls = 31'($urandom_range(0, 2 * ONE));
				end
				default: begin
					vs = VALIDITY_RESET;
					ls = LINK_RESET;
				end
			endcase
			settle_block();
			write_slack(REG_VALIDITY, vs);
			write_slack(REG_LINK, ls);
			send_clear();
			run_scenes(150);
		end
	endtask

	// Long receiver hold while portals keep coming, so the input stalls.
	task automatic test_output_hold();
		send_clear();
		repeat (8) place_zone();
		rx_hold_req = 400;
		repeat (30) place_portal();
		settle_block();
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_clear();
		run_scenes(350);
	endtask

	initial begin
		int waited;
		validity_q = VALIDITY_RESET;
		link_q = LINK_RESET;
		box_open = 1'b0;
		zones_held = 0;
		portals_kept = '0;
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = 0;
			box_hi[a] = 0;
		end
		new_scene();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_store_full();
		test_slack_settings();
		test_output_hold();
		test_full_rate();

		// Drain: every prediction must be matched, then let the block go quiet.
		in_valid <= 1'b0;
		waited = 0;
		while (expected_links.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_links.size() != 0) begin
			$error("results still outstanding: %0d", expected_links.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (mismatch_count == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
